>>> sv/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window maximum unit
// Field widths, register reset value and the result record handed from the
// deque sequencer to the output stage.
// ----------------------------------------------------------------------------
package swm_pkg;

    // sample and register widths
    localparam int SAMPLE_W = 32;
    localparam int LEN_W    = 7;

    // default deque depth and window length after reset
    localparam int              WINDOW_DEPTH_DEF = 64;
    localparam logic [LEN_W-1:0] LEN_RESET        = 7'd3;

    // one window maximum leaving the sequencer
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
    } result_t;

endpackage
`default_nettype wire

>>> sv/swm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> sv/swm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ctrl: monotonic deque sequencer
// Keeps head, count and arrival position of the candidate deque whose entries
// live in the RAM. Per sample it pops expired candidates off the front, pops
// smaller or equal candidates off the back, then appends the sample.
// ----------------------------------------------------------------------------
module swm_ctrl
#(
    parameter int WINDOW_DEPTH = 64,
    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1),
    localparam int POS_W  = $clog2(2 * WINDOW_DEPTH),
    localparam int WORD_W = swm_pkg::SAMPLE_W + POS_W
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // sample request
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [swm_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic                              in_restart,
    // effective window length, 1..WINDOW_DEPTH
    input  wire logic [CNT_W-1:0]                  win_len,
    // output stage can take a result this cycle
    input  wire logic                              out_free,
    output swm_pkg::result_t                       res,
    // candidate RAM
    output logic                                   ram_we,
    output logic [ADDR_W-1:0]                      ram_waddr,
    output logic [WORD_W-1:0]                      ram_wdata,
    output logic [ADDR_W-1:0]                      ram_raddr,
    input  wire logic [WORD_W-1:0]                 ram_rdata
);

    import swm_pkg::*;

    localparam int SUM_W  = CNT_W + 1;
    localparam int DIFF_W = POS_W + 1;
    localparam int SPAN   = 2 * WINDOW_DEPTH;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FRONT  = 2'd1;
    localparam logic [1:0] S_BACK   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [ADDR_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [CNT_W-1:0]          seen_reg, seen_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] front_reg, front_next;

    logic signed [SAMPLE_W-1:0] rd_value;
    logic [POS_W-1:0]          rd_pos;
    logic [DIFF_W-1:0]         age;
    logic                      expired;
    logic [CNT_W-1:0]          seen_inc;
    logic                      produce;

    // deque slot at an offset from a base, modulo the depth
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(WINDOW_DEPTH))
        begin
            sum = sum - SUM_W'(WINDOW_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // fields of the entry read last cycle
    assign rd_value = $signed(ram_rdata[SAMPLE_W-1:0]);
    assign rd_pos   = ram_rdata[SAMPLE_W +: POS_W];

    // age of the entry, modulo the position span
    always_comb
    begin
        if (pos_reg >= rd_pos)
        begin
            age = DIFF_W'(pos_reg) - DIFF_W'(rd_pos);
        end
        else
        begin
            age = DIFF_W'(pos_reg) + DIFF_W'(SPAN) - DIFF_W'(rd_pos);
        end
    end
    assign expired = (age >= DIFF_W'(win_len));

    // samples since restart, saturating at the window length
    assign seen_inc = (seen_reg < win_len) ? seen_reg + CNT_W'(1) : seen_reg;
    assign produce  = (seen_inc >= win_len);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        x_next     = x_reg;
        front_next = front_reg;
        in_ready   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = slot_of(head_reg, count_reg);
        ram_wdata  = {pos_reg, x_reg};
        ram_raddr  = head_reg;
        res.valid  = 1'b0;
        res.value  = (count_reg == '0) ? x_reg : front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    x_next = in_sample;
                    if (in_restart)
                    begin
                        head_next  = '0;
                        count_next = '0;
                        pos_next   = '0;
                        seen_next  = '0;
                    end
                    // fetch the front candidate
                    ram_raddr  = head_next;
                    state_next = (count_next != '0) ? S_FRONT : S_FINISH;
                end
            end
            S_FRONT:
            begin
                if (expired)
                begin
                    // front left the window, look at the next one
                    head_next  = slot_of(head_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                    ram_raddr  = head_next;
                    state_next = (count_reg == CNT_W'(1)) ? S_FINISH : S_FRONT;
                end
                else
                begin
                    // front stays; fetch the back candidate
                    front_next = rd_value;
                    ram_raddr  = slot_of(head_reg, count_reg - CNT_W'(1));
                    state_next = S_BACK;
                end
            end
            S_BACK:
            begin
                if (x_reg >= rd_value)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ram_raddr  = slot_of(head_reg, count_reg - CNT_W'(2));
                    state_next = (count_reg == CNT_W'(1)) ? S_FINISH : S_BACK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // append the sample and report once the output can take it
                if (!produce || out_free)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    pos_next   = (pos_reg == POS_W'(SPAN - 1)) ? '0 : pos_reg + POS_W'(1);
                    seen_next  = seen_inc;
                    res.valid  = produce;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        front_reg <= front_next;
    end

endmodule
`default_nettype wire

>>> sv/sliding_window_maximum_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_maximum_unit: streaming maximum over the last N samples
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tdata = sample, tuser = restart
//   m_axis    out  tvalid/tready           tdata = window_max
//   cfg       in   cfg_wr_en               cfg_wr_data = window_length
//
// One sample at a time: with the deque empty (or emptied by a restart) the
// sequencer goes straight to the append step; otherwise it steps through
// each expired front candidate, a surviving front and each back comparison,
// read through the single RAM read port, one deque entry per cycle.
// Reset empties the deque and loads a window length of 3; the RAM needs no
// clearing since only live deque entries are read.
// A result waits in the output register while the next sample is taken;
// the sequencer holds its append only if that register is still full.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit
#(
    parameter int WINDOW_DEPTH = swm_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // [31:0] sample
    input  wire logic                           s_axis_tuser,  // [0] restart
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [swm_pkg::SAMPLE_W-1:0]        m_axis_tdata,  // [31:0] window_max
    input  wire logic                           cfg_wr_en,
    input  wire logic [swm_pkg::LEN_W-1:0]      cfg_wr_data
);

    import swm_pkg::*;

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W  = $clog2(2 * WINDOW_DEPTH);
    localparam int WORD_W = SAMPLE_W + POS_W;
    localparam int EXT_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [LEN_W-1:0]    len_reg;
    logic [CNT_W-1:0]    win_len;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_free;
    result_t             res;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    // window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            len_reg <= cfg_wr_data;
        end
    end

    // zero counts as one, lengths beyond the depth clamp to it
    always_comb
    begin
        if (len_reg == '0)
        begin
            win_len = CNT_W'(1);
        end
        else if (EXT_W'(len_reg) > EXT_W'(WINDOW_DEPTH))
        begin
            win_len = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            win_len = CNT_W'(len_reg);
        end
    end

    // output register
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_data_reg <= res.value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // deque sequencer
    swm_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  ($signed(s_axis_tdata)),
        .in_restart (s_axis_tuser),
        .win_len    (win_len),
        .out_free   (out_free),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // candidate store: {arrival position, value}
    swm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_cand_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // a result never lands on an output register that is still full
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result overwrote a pending window maximum");

    // the sequencer is not ready again in the cycle after it takes a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sample taken while the previous one is in progress");

    // a new result only follows a sample that was in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a sample in progress");

    // the RAM is never written while a sample is being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !s_axis_tready)
        else $error("candidate write outside the append step");

endmodule
`default_nettype wire
